// ===== rtl/matrix3x3_inverse_assert.svh =====
// Assertion macros for the 3x3 inverse block.
// Each macro expects clk and arst_n to be visible where it is used.
`ifndef MATRIX3X3_INVERSE_ASSERT_SVH
`define MATRIX3X3_INVERSE_ASSERT_SVH

// Same-cycle implication.
`define M3I_ASSERT_IMP(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("matrix3x3_inverse: assertion failed");

// Next-cycle implication.
`define M3I_ASSERT_NXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("matrix3x3_inverse: assertion failed");

`endif

// ===== rtl/m3i_pkg.sv =====
`timescale 1ns / 1ps
package m3i_pkg;

	localparam int LANES = 9;

	// Operand indices of each cofactor: adj = a[i0]*a[i1] - a[i2]*a[i3].
	localparam int COF_IDX [LANES][4] = '{
		'{4, 8, 5, 7},
		'{1, 8, 2, 7},
		'{1, 5, 2, 4},
		'{3, 8, 5, 6},
		'{0, 8, 2, 6},
		'{0, 5, 2, 3},
		'{3, 7, 4, 6},
		'{0, 7, 1, 6},
		'{0, 4, 1, 3}
	};

	// Cofactors whose sign is flipped in the adjugate.
	localparam logic [LANES-1:0] COF_NEG = 9'b010101010;

	typedef struct packed {
		logic singular;
		logic det_neg;
	} m3i_flags_t;

endpackage

// ===== rtl/m3i_mat_if.sv =====
`timescale 1ns / 1ps
interface m3i_mat_if #(parameter int WORD_BITS = 32) ();
	logic valid;
	logic ready;
	logic signed [WORD_BITS-1:0] a00, a01, a02, a10, a11, a12, a20, a21, a22;

	modport source (output valid, a00, a01, a02, a10, a11, a12, a20, a21, a22,
		input ready);
	modport sink (input valid, a00, a01, a02, a10, a11, a12, a20, a21, a22,
		output ready);
endinterface

// ===== rtl/m3i_inv_if.sv =====
`timescale 1ns / 1ps
interface m3i_inv_if #(parameter int WORD_BITS = 32) ();
	logic valid;
	logic ready;
	logic signed [WORD_BITS-1:0] b00, b01, b02, b10, b11, b12, b20, b21, b22;
	logic singular;
	logic overflowed;

	modport source (output valid, b00, b01, b02, b10, b11, b12, b20, b21, b22,
		singular, overflowed, input ready);
	modport sink (input valid, b00, b01, b02, b10, b11, b12, b20, b21, b22,
		singular, overflowed, output ready);
endinterface

// ===== rtl/m3i_front.sv =====
`timescale 1ns / 1ps
module m3i_front #(
	parameter int WORD_BITS = 32,
	parameter int FRAC_BITS = 16,
	localparam int DM = ((3*WORD_BITS+1) > (3*FRAC_BITS+1)) ? (3*WORD_BITS+1) : (3*FRAC_BITS+1)
) (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	input  logic [m3i_pkg::LANES-1:0][WORD_BITS-1:0] in_a,
	output logic out_valid,
	input  logic out_ready,
	output logic [m3i_pkg::LANES-1:0][2*WORD_BITS-1:0] out_adjm,
	output logic [m3i_pkg::LANES-1:0] out_adjneg,
	output logic [DM-1:0] out_detm,
	output m3i_pkg::m3i_flags_t out_flags
);

	localparam int W  = WORD_BITS;
	localparam int N  = m3i_pkg::LANES;
	localparam int PW = 2*W;
	localparam int AW = 2*W+1;
	localparam int TW = 2*W+2;
	localparam int SW = TW+2;
	localparam int DS = DM+1;
	localparam int AM = 2*W;

	logic en;
	logic vld_s1, vld_s2, vld_s3, vld_s4, vld_s5, vld_s6, vld_s7;

	logic signed [W-1:0]  a_s1 [N];
	logic signed [PW-1:0] p_s2 [2*N];
	logic signed [W-1:0]  r0_s2 [3];
	logic signed [W-1:0]  r0_s3 [3];
	logic signed [AW-1:0] adj_s3 [N];
	logic signed [AW-1:0] adj_s4 [N];
	logic signed [TW-1:0] plo_s4 [3];
	logic signed [TW-1:0] phi_s4 [3];
	logic signed [SW-1:0] lsum_s5, hsum_s5;
	logic [AM-1:0] adjm_s5 [N];
	logic [AM-1:0] adjm_s6 [N];
	logic [AM-1:0] adjm_s7 [N];
	logic [N-1:0]  adjneg_s5, adjneg_s6, adjneg_s7;
	logic signed [DS-1:0] det_s6;
	logic [DM-1:0] detm_s7;
	m3i_pkg::m3i_flags_t flags_s7;

	logic signed [PW-1:0] p_n [2*N];
	logic signed [AW-1:0] adj_n [N];
	logic signed [TW-1:0] plo_n [3];
	logic signed [TW-1:0] phi_n [3];
	logic signed [SW-1:0] lsum_n, hsum_n;
	logic [AM-1:0] adjm_n [N];
	logic [N-1:0]  adjneg_n;
	logic signed [DS-1:0] det_n;
	logic [DM-1:0] detm_n;
	m3i_pkg::m3i_flags_t flags_n;

	assign en = !vld_s7 || out_ready;
	assign in_ready = en;

	always_comb begin
		logic [AW-1:0] amag;
		logic [DS-1:0] dmag;
		logic signed [DS-1:0] hx;
		logic [W-1:0] lo;
		logic signed [W:0] hi;
		for (int k = 0; k < N; k++) begin
			p_n[2*k]   = a_s1[m3i_pkg::COF_IDX[k][0]] * a_s1[m3i_pkg::COF_IDX[k][1]];
			p_n[2*k+1] = a_s1[m3i_pkg::COF_IDX[k][2]] * a_s1[m3i_pkg::COF_IDX[k][3]];
		end
		for (int k = 0; k < N; k++) begin
			if (m3i_pkg::COF_NEG[k]) begin
				adj_n[k] = p_s2[2*k+1] - p_s2[2*k];
			end else begin
				adj_n[k] = p_s2[2*k] - p_s2[2*k+1];
			end
		end
		// The three cofactors used in the first-row expansion are each split into a low word and a
		// signed high part, so the expansion only needs narrow multipliers.
		for (int i = 0; i < 3; i++) begin
			lo = adj_s3[3*i][W-1:0];
			hi = adj_s3[3*i][AW-1:W];
			plo_n[i] = r0_s3[i] * $signed({1'b0, lo});
			phi_n[i] = r0_s3[i] * hi;
		end
		lsum_n = plo_s4[0];
		lsum_n = lsum_n + plo_s4[1] + plo_s4[2];
		hsum_n = phi_s4[0];
		hsum_n = hsum_n + phi_s4[1] + phi_s4[2];
		for (int k = 0; k < N; k++) begin
			adjneg_n[k] = adj_s4[k][AW-1];
			amag = adj_s4[k][AW-1] ? -adj_s4[k] : adj_s4[k];
			adjm_n[k] = amag[AM-1:0];
		end
		hx = hsum_s5;
		det_n = (hx <<< W) + lsum_s5;
		dmag = det_s6[DS-1] ? -det_s6 : det_s6;
		flags_n.singular = (det_s6 == '0);
		flags_n.det_neg = det_s6[DS-1];
		if (flags_n.singular) begin
			detm_n = '0;
			detm_n[3*FRAC_BITS] = 1'b1;
		end else begin
			detm_n = dmag[DM-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
			vld_s6 <= 1'b0;
			vld_s7 <= 1'b0;
		end else if (en) begin
			vld_s1 <= in_valid;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
			vld_s5 <= vld_s4;
			vld_s6 <= vld_s5;
			vld_s7 <= vld_s6;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < N; k++) begin
				a_s1[k] <= in_a[k];
				adj_s3[k] <= adj_n[k];
				adj_s4[k] <= adj_s3[k];
				adjm_s5[k] <= adjm_n[k];
				adjm_s6[k] <= adjm_s5[k];
				adjm_s7[k] <= adjm_s6[k];
			end
			for (int j = 0; j < 2*N; j++) begin
				p_s2[j] <= p_n[j];
			end
			for (int i = 0; i < 3; i++) begin
				r0_s2[i] <= a_s1[i];
				r0_s3[i] <= r0_s2[i];
				plo_s4[i] <= plo_n[i];
				phi_s4[i] <= phi_n[i];
			end
			lsum_s5 <= lsum_n;
			hsum_s5 <= hsum_n;
			adjneg_s5 <= adjneg_n;
			adjneg_s6 <= adjneg_s5;
			adjneg_s7 <= adjneg_s6;
			det_s6 <= det_n;
			detm_s7 <= detm_n;
			flags_s7 <= flags_n;
		end
	end

	assign out_valid = vld_s7;
	assign out_detm = detm_s7;
	assign out_flags = flags_s7;
	assign out_adjneg = adjneg_s7;
	always_comb begin
		for (int k = 0; k < N; k++) begin
			out_adjm[k] = adjm_s7[k];
		end
	end

endmodule

// ===== rtl/m3i_queue.sv =====
`timescale 1ns / 1ps
module m3i_queue #(
	parameter int DATA_W = 8
) (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	input  logic [DATA_W-1:0] in_data,
	output logic out_valid,
	input  logic out_ready,
	output logic [DATA_W-1:0] out_data
);

	localparam int QDEPTH = 4;
	localparam int PTR_W = $clog2(QDEPTH);
	localparam int CNT_W = $clog2(QDEPTH+1);

	logic [DATA_W-1:0] slot_q [QDEPTH];
	logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0] cnt_q;
	logic push, pop;

	assign in_ready = (cnt_q != CNT_W'(QDEPTH));
	assign out_valid = (cnt_q != '0);
	assign out_data = slot_q[rd_ptr_q];
	assign push = in_valid && in_ready;
	assign pop = out_valid && out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= in_data;
		end
	end

endmodule

// ===== rtl/m3i_back.sv =====
`timescale 1ns / 1ps
module m3i_back #(
	parameter int WORD_BITS = 32,
	parameter int FRAC_BITS = 16,
	localparam int DM = ((3*WORD_BITS+1) > (3*FRAC_BITS+1)) ? (3*WORD_BITS+1) : (3*FRAC_BITS+1)
) (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	input  logic [m3i_pkg::LANES-1:0][2*WORD_BITS-1:0] in_adjm,
	input  logic [m3i_pkg::LANES-1:0] in_adjneg,
	input  logic [DM-1:0] in_detm,
	input  m3i_pkg::m3i_flags_t in_flags,
	output logic out_valid,
	input  logic out_ready,
	output logic [m3i_pkg::LANES-1:0][WORD_BITS-1:0] out_b,
	output logic out_singular,
	output logic out_overflowed
);

	localparam int W = WORD_BITS;
	localparam int N = m3i_pkg::LANES;
	localparam int DEN_W = DM+1;
	localparam int NX = ((2*W+2*FRAC_BITS+1) > DM) ? (2*W+2*FRAC_BITS+1) : DM;
	localparam int NW = NX+1;
	localparam int RW = ((NW > DEN_W+W) ? NW : DEN_W+W) + 1;

	logic en;
	logic [W:0] vld_s;
	logic [RW-1:0] rem_s [W+1][N];
	logic [W-1:0] q_s [W+1][N];
	logic [DEN_W-1:0] den_s [W+1];
	logic [N-1:0] neg_s [W+1];
	logic [N-1:0] ovf_s [W+1];
	logic sing_s [W+1];

	logic [RW-1:0] rem_n [W+1][N];
	logic [W-1:0] q_n [W+1][N];
	logic [DEN_W-1:0] den_n [W+1];
	logic [N-1:0] neg_n [W+1];
	logic [N-1:0] ovf_n [W+1];
	logic sing_n [W+1];

	logic vld_out_q;
	logic [W-1:0] b_q [N];
	logic sing_q, ovf_q;
	logic [W-1:0] b_n [N];
	logic ovf_any_n;

	assign en = !vld_out_q || out_ready;
	assign in_ready = en;

	always_comb begin
		logic [RW-1:0] num, trial, dext;
		logic [W-1:0] lim, mag;
		logic sat;
		// Entry step: rounding folded in as (2*adj*2^2F + det) / (2*det).
		den_n[0] = {in_detm, 1'b0};
		sing_n[0] = in_flags.singular;
		for (int l = 0; l < N; l++) begin
			num = RW'(in_adjm[l]);
			num = num << (2*FRAC_BITS+1);
			dext = RW'(in_detm);
			num = num + dext;
			trial = RW'(den_n[0]);
			trial = trial << W;
			rem_n[0][l] = num;
			q_n[0][l] = '0;
			ovf_n[0][l] = (num >= trial);
			neg_n[0][l] = (in_adjneg[l] ^ in_flags.det_neg) && (in_adjm[l] != '0);
		end
		// One restoring quotient bit per stage, most significant first.
		for (int j = 1; j <= W; j++) begin
			den_n[j] = den_s[j-1];
			sing_n[j] = sing_s[j-1];
			neg_n[j] = neg_s[j-1];
			ovf_n[j] = ovf_s[j-1];
			for (int l = 0; l < N; l++) begin
				trial = RW'(den_s[j-1]);
				trial = trial << (W-j);
				q_n[j][l] = q_s[j-1][l];
				if (rem_s[j-1][l] >= trial) begin
					rem_n[j][l] = rem_s[j-1][l] - trial;
					q_n[j][l][W-j] = 1'b1;
				end else begin
					rem_n[j][l] = rem_s[j-1][l];
				end
			end
		end
		ovf_any_n = 1'b0;
		for (int l = 0; l < N; l++) begin
			lim = '1;
			lim[W-1] = 1'b0;
			if (neg_s[W][l]) begin
				lim = '0;
				lim[W-1] = 1'b1;
			end
			sat = ovf_s[W][l] || (q_s[W][l] > lim);
			mag = sat ? lim : q_s[W][l];
			b_n[l] = neg_s[W][l] ? -mag : mag;
			ovf_any_n = ovf_any_n | sat;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
			vld_out_q <= 1'b0;
		end else if (en) begin
			vld_s <= {vld_s[W-1:0], in_valid};
			vld_out_q <= vld_s[W];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int j = 0; j <= W; j++) begin
				den_s[j] <= den_n[j];
				sing_s[j] <= sing_n[j];
				neg_s[j] <= neg_n[j];
				ovf_s[j] <= ovf_n[j];
				for (int l = 0; l < N; l++) begin
					rem_s[j][l] <= rem_n[j][l];
					q_s[j][l] <= q_n[j][l];
				end
			end
			for (int l = 0; l < N; l++) begin
				b_q[l] <= b_n[l];
			end
			sing_q <= sing_s[W];
			ovf_q <= ovf_any_n;
		end
	end

	assign out_valid = vld_out_q;
	assign out_singular = sing_q;
	assign out_overflowed = ovf_q;
	always_comb begin
		for (int l = 0; l < N; l++) begin
			out_b[l] = b_q[l];
		end
	end

endmodule

// ===== rtl/matrix3x3_inverse.sv =====
// 3x3 matrix inverse by the adjugate. One matrix transfer per cycle is taken and one
// result per cycle is delivered in steady state, as long as inv.ready does not stall the
// output. A seven-stage front end forms the cofactors and the determinant and writes
// them into a four-entry queue. The back end is a pipelined restoring divider: an entry
// stage, then WORD_BITS stages that each settle one quotient bit for all nine entries at
// once. Rounding and saturation feed the output register. A zero determinant gives the
// adjugate with singular set, and any saturated entry sets overflowed.
`timescale 1ns / 1ps
module matrix3x3_inverse #(
	parameter int WORD_BITS = 32,
	parameter int FRAC_BITS = 16,
	localparam int DM = ((3*WORD_BITS+1) > (3*FRAC_BITS+1)) ? (3*WORD_BITS+1) : (3*FRAC_BITS+1)
) (
	input logic clk,
	input logic arst_n,
	m3i_mat_if.sink mat,
	m3i_inv_if.source inv
);

	localparam int N = m3i_pkg::LANES;
	localparam int AM = 2*WORD_BITS;
	localparam int EW = $bits(m3i_pkg::m3i_flags_t) + N + N*AM + DM;

	logic [N-1:0][WORD_BITS-1:0] in_a;
	logic fr_valid, q_in_ready;
	logic [N-1:0][AM-1:0] fr_adjm;
	logic [N-1:0] fr_adjneg;
	logic [DM-1:0] fr_detm;
	m3i_pkg::m3i_flags_t fr_flags;
	logic [EW-1:0] q_in_data, q_out_data;
	logic q_out_valid, bk_in_ready;
	logic [N-1:0][AM-1:0] bk_adjm;
	logic [N-1:0] bk_adjneg;
	logic [DM-1:0] bk_detm;
	m3i_pkg::m3i_flags_t bk_flags;
	logic [N-1:0][WORD_BITS-1:0] bk_b;

	assign in_a[0] = mat.a00;
	assign in_a[1] = mat.a01;
	assign in_a[2] = mat.a02;
	assign in_a[3] = mat.a10;
	assign in_a[4] = mat.a11;
	assign in_a[5] = mat.a12;
	assign in_a[6] = mat.a20;
	assign in_a[7] = mat.a21;
	assign in_a[8] = mat.a22;

	m3i_front #(.WORD_BITS(WORD_BITS), .FRAC_BITS(FRAC_BITS)) u_front (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(mat.valid),
		.in_ready(mat.ready),
		.in_a(in_a),
		.out_valid(fr_valid),
		.out_ready(q_in_ready),
		.out_adjm(fr_adjm),
		.out_adjneg(fr_adjneg),
		.out_detm(fr_detm),
		.out_flags(fr_flags)
	);

	assign q_in_data = {fr_flags, fr_adjneg, fr_adjm, fr_detm};

	m3i_queue #(.DATA_W(EW)) u_queue (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(fr_valid),
		.in_ready(q_in_ready),
		.in_data(q_in_data),
		.out_valid(q_out_valid),
		.out_ready(bk_in_ready),
		.out_data(q_out_data)
	);

	assign {bk_flags, bk_adjneg, bk_adjm, bk_detm} = q_out_data;

	m3i_back #(.WORD_BITS(WORD_BITS), .FRAC_BITS(FRAC_BITS)) u_back (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(q_out_valid),
		.in_ready(bk_in_ready),
		.in_adjm(bk_adjm),
		.in_adjneg(bk_adjneg),
		.in_detm(bk_detm),
		.in_flags(bk_flags),
		.out_valid(inv.valid),
		.out_ready(inv.ready),
		.out_b(bk_b),
		.out_singular(inv.singular),
		.out_overflowed(inv.overflowed)
	);

	assign inv.b00 = bk_b[0];
	assign inv.b01 = bk_b[1];
	assign inv.b02 = bk_b[2];
	assign inv.b10 = bk_b[3];
	assign inv.b11 = bk_b[4];
	assign inv.b12 = bk_b[5];
	assign inv.b20 = bk_b[6];
	assign inv.b21 = bk_b[7];
	assign inv.b22 = bk_b[8];

`include "matrix3x3_inverse_assert.svh"

	// The front end only stops when the queue is full.
	`M3I_ASSERT_IMP(a_front_moves, q_in_ready, mat.ready)
	// An empty output register always lets the divider pipeline advance.
	`M3I_ASSERT_IMP(a_back_drains, !inv.valid, bk_in_ready)
	// A queued entry waiting on the divider stays put.
	`M3I_ASSERT_NXT(a_queue_holds, q_out_valid && !bk_in_ready,
		q_out_valid && $stable(q_out_data))

endmodule

// ===== verif/matrix3x3_inverse_checker.sv =====
`timescale 1ns / 1ps
module matrix3x3_inverse_checker #(
	parameter int WORD_BITS = 32,
	parameter int FRAC_BITS = 16
) (
	input logic clk,
	input logic arst_n,
	m3i_mat_if mat,
	m3i_inv_if inv,
	output int fail_count,
	output int inverses_pending
);

	typedef struct {
		logic signed [WORD_BITS-1:0] e [m3i_pkg::LANES];
	} matrix_t;

	typedef struct {
		logic signed [WORD_BITS-1:0] b [m3i_pkg::LANES];
		logic singular;
		logic overflowed;
	} inverse_t;

	inverse_t expected_inverses [$];
	int mismatches = 0;
	int pending = 0;

	assign fail_count = mismatches;
	assign inverses_pending = pending;

	// Exact adjugate and determinant, then a rounded and saturated quotient per entry.
	function automatic inverse_t invert_matrix(matrix_t m);
		logic signed [255:0] a [m3i_pkg::LANES];
		logic signed [255:0] adj [m3i_pkg::LANES];
		logic signed [255:0] det;
		logic [255:0] adj_mag, det_mag, q, lim;
		logic neg;
		inverse_t r;
		for (int i = 0; i < m3i_pkg::LANES; i++)
			a[i] = m.e[i];
		for (int i = 0; i < m3i_pkg::LANES; i++) begin
			adj[i] = a[m3i_pkg::COF_IDX[i][0]] * a[m3i_pkg::COF_IDX[i][1]]
				- a[m3i_pkg::COF_IDX[i][2]] * a[m3i_pkg::COF_IDX[i][3]];
			if (m3i_pkg::COF_NEG[i])
				adj[i] = -adj[i];
		end
		det = a[0] * adj[0] + a[1] * adj[3] + a[2] * adj[6];
		r.singular = (det == 0);
		r.overflowed = 1'b0;
		// A zero determinant is replaced by 1.0 at three times the fraction width.
		if (r.singular)
			det = 256'sd1 <<< (3 * FRAC_BITS);
		det_mag = (det < 0) ? -det : det;
		for (int i = 0; i < m3i_pkg::LANES; i++) begin
			adj_mag = (adj[i] < 0) ? -adj[i] : adj[i];
			neg = ((adj[i] < 0) != (det < 0)) && (adj[i] != 0);
			q = ((adj_mag << (2 * FRAC_BITS + 1)) + det_mag) / (det_mag << 1);
			lim = neg ? (256'd1 << (WORD_BITS - 1)) : ((256'd1 << (WORD_BITS - 1)) - 1);
			if (q > lim) begin
				q = lim;
				r.overflowed = 1'b1;
			end
			r.b[i] = neg ? -q[WORD_BITS-1:0] : q[WORD_BITS-1:0];
		end
		return r;
	endfunction

	always @(posedge clk) begin
		matrix_t m;
		inverse_t got, want;
		logic bad;
		if (arst_n) begin
			if (mat.valid && mat.ready) begin
				m.e = '{mat.a00, mat.a01, mat.a02, mat.a10, mat.a11, mat.a12,
					mat.a20, mat.a21, mat.a22};
				expected_inverses.push_back(invert_matrix(m));
			end
			if (inv.valid && inv.ready) begin
				got.b = '{inv.b00, inv.b01, inv.b02, inv.b10, inv.b11, inv.b12,
					inv.b20, inv.b21, inv.b22};
				got.singular = inv.singular;
				got.overflowed = inv.overflowed;
				if (expected_inverses.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("%0t: result transfer with no matrix outstanding", $realtime);
				end else begin
					want = expected_inverses.pop_front();
					bad = (got.singular !== want.singular) || (got.overflowed !== want.overflowed);
					for (int i = 0; i < m3i_pkg::LANES; i++)
						if (got.b[i] !== want.b[i])
							bad = 1'b1;
					if (bad) begin
						mismatches++;
						if (mismatches <= 10) begin
							$display("%0t: inverse mismatch, singular %b/%b overflowed %b/%b",
								$realtime, want.singular, got.singular,
								want.overflowed, got.overflowed);
							for (int i = 0; i < m3i_pkg::LANES; i++)
								$display("  b%0d%0d expected %h got %h", i / 3, i % 3,
									want.b[i], got.b[i]);
						end
					end
				end
			end
			pending = expected_inverses.size();
		end
	end
endmodule

// ===== verif/matrix3x3_inverse_test.sv =====
`timescale 1ns / 1ps
module matrix3x3_inverse_test;
	localparam int WB = 32;
	localparam int FB = 16;
	localparam int ONE = 1 << FB;
	localparam int RANDOM_MATRICES = 1630;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	int fail_count, inverses_pending;
	bit burst_mode = 1'b0;

	m3i_mat_if #(.WORD_BITS(WB)) mat ();
	m3i_inv_if #(.WORD_BITS(WB)) inv ();

	matrix3x3_inverse #(.WORD_BITS(WB), .FRAC_BITS(FB)) dut (
		.clk(clk), .arst_n(arst_n), .mat(mat), .inv(inv));

	matrix3x3_inverse_checker #(.WORD_BITS(WB), .FRAC_BITS(FB)) checker_i (
		.clk(clk), .arst_n(arst_n), .mat(mat), .inv(inv),
		.fail_count(fail_count), .inverses_pending(inverses_pending));

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	initial begin
		#5ms;
		$display("[FAIL] regression broken");
		$finish;
	end

	function automatic int idle_cycles();
		int r;
		r = $urandom_range(0, 99);
		if (burst_mode || r < 50)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	task automatic send_matrix(input logic [WB-1:0] e [9]);
		int gap;
		gap = idle_cycles();
		if (gap > 0) begin
			mat.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		mat.valid <= 1'b1;
		{mat.a00, mat.a01, mat.a02, mat.a10, mat.a11, mat.a12, mat.a20, mat.a21, mat.a22}
			<= {e[0], e[1], e[2], e[3], e[4], e[5], e[6], e[7], e[8]};
		do @(posedge clk); while (!mat.ready);
	endtask

	task automatic send_diag(input int d0, input int d1, input int d2, input int off);
		send_matrix('{d0, off, off, off, d1, off, off, off, d2});
	endtask

	// Receiver: random stalls, with one long hold-off early on so the front end backs up.
	initial begin
		int cycles;
		cycles = 0;
		inv.ready <= 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			cycles++;
			if (cycles == 400) begin
				inv.ready <= 1'b0;
				repeat (300) @(posedge clk);
				cycles += 300;
			end else begin
				inv.ready <= (idle_cycles() == 0);
			end
		end
	end

	initial begin
		logic [WB-1:0] e [9];
		int kind;
		mat.valid <= 1'b0;
		{mat.a00, mat.a01, mat.a02, mat.a10, mat.a11, mat.a12, mat.a20, mat.a21, mat.a22} <= '0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed cases: zero, identity, scaled identities, extremes and singular shapes.
		send_diag(0, 0, 0, 0);
		send_diag(ONE, ONE, ONE, 0);
		send_diag(-ONE, 2 * ONE, ONE / 2, 0);
		send_diag(1, 1, 1, 0);
		send_diag(3, 3, 3, 0);
		send_diag(ONE * 3, ONE * 3, ONE * 3, 0);
		send_diag(32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 0);
		send_diag(32'h80000000, 32'h80000000, 32'h80000000, 0);
		send_diag(32'h7fffffff, 32'h80000000, 32'h7fffffff, 32'h80000000);
		send_diag(ONE, ONE, ONE, ONE);
		send_diag(32'h80000000, 32'h80000000, 32'h80000000, 32'h80000000);
		send_diag(32'hffffffff, 32'hffffffff, 32'hffffffff, 0);
		send_matrix('{ONE, 2 * ONE, 3 * ONE, 4 * ONE, 5 * ONE, 6 * ONE, 7 * ONE, 8 * ONE,
			9 * ONE});
		send_matrix('{ONE, 2 * ONE, 3 * ONE, 0, ONE, 4 * ONE, 5 * ONE, 6 * ONE, 0});
		send_matrix('{2 * ONE, -ONE, 0, -ONE, 2 * ONE, -ONE, 0, -ONE, 2 * ONE});
		send_matrix('{0, ONE, 0, ONE, 0, 0, 0, 0, ONE});
		send_matrix('{3 * ONE, 0, 0, 0, 3 * ONE, 0, 0, 0, 3 * ONE});
		send_matrix('{32'h7fffffff, 32'h80000000, 1, 32'hffffffff, 0, 32'h7fffffff, 1,
			32'h80000000, 32'h7fffffff});

		for (int n = 0; n < RANDOM_MATRICES; n++) begin
			if (n % 200 == 0)
				burst_mode = ($urandom_range(0, 2) == 0);
			kind = $urandom_range(0, 9);
			for (int i = 0; i < 9; i++) begin
				case (kind)
					0, 1: e[i] = $urandom;
					2: e[i] = $signed($urandom) >>> $urandom_range(0, 31);
					3, 4: e[i] = (int'($urandom_range(0, 6)) - 3) * ONE;
					default: e[i] = (i % 4 == 0)
						? ($urandom_range(0, 1) ? 1 : -1) * int'($urandom_range(ONE / 2, 4 * ONE))
						: int'($urandom_range(0, ONE)) - ONE / 2;
				endcase
			end
			// Occasionally make a row a copy of another so the determinant vanishes.
			if (kind == 5 || kind == 1)
				for (int c = 0; c < 3; c++)
					e[6 + c] = e[c];
			send_matrix(e);
		end
		mat.valid <= 1'b0;

		// The last transfer is counted by the checker at the edge just passed.
		do @(posedge clk); while (inverses_pending != 0);
		repeat (60) @(posedge clk);
		if (fail_count == 0 && inverses_pending == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end
endmodule
